// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a property holds on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/rgbhsl_pkg.sv -----
package rgbhsl_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned HueW    = 9;
  localparam int unsigned PctW    = 7;
  localparam int unsigned SumW    = 9;   // max + min, up to 510
  localparam int unsigned NumW    = 17;  // hue numerator, up to 360*255
  localparam int unsigned DivStgs = 17;  // quotient bits, one per stage

  // Hue sector codes.
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  // Per-pixel quantities after the front end.
  typedef struct packed {
    logic [NumW-1:0] hue_num;   // hue numerator, already wrapped
    logic [NumW-1:0] sat_num;   // 100 * spread
    logic [SumW-1:0] den;       // spread for hue, sat denominator below
    logic [SumW-1:0] sat_den;   // saturation denominator
    logic [PctW-1:0] light;
    logic            grey;
  } front_t;

endpackage

// ----- hw/rtl/rgbhsl_front.sv -----
// Front end: max/min, sector, numerators, lightness. Three register stages.
module rgbhsl_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  logic [rgbhsl_pkg::ChanW-1:0]        red,
  input  logic [rgbhsl_pkg::ChanW-1:0]        green,
  input  logic [rgbhsl_pkg::ChanW-1:0]        blue,
  output logic                                out_vld,
  output rgbhsl_pkg::front_t                  out_data
);

  // stage 1: max/min and sector
  logic [7:0] mx_nxt, mn_nxt;
  rgbhsl_pkg::sector_t sec_nxt;
  logic [7:0] r1_r, g1_r, b1_r, mx1_r, mn1_r;
  rgbhsl_pkg::sector_t sec1_r;
  logic v1_r;

  always_comb begin
    mx_nxt = red;
    mn_nxt = red;
    if (green > mx_nxt) mx_nxt = green;
    if (blue > mx_nxt) mx_nxt = blue;
    if (green < mn_nxt) mn_nxt = green;
    if (blue < mn_nxt) mn_nxt = blue;
    if (blue == mx_nxt)       sec_nxt = rgbhsl_pkg::SEC_BLUE;
    else if (green == mx_nxt) sec_nxt = rgbhsl_pkg::SEC_GREEN;
    else                      sec_nxt = rgbhsl_pkg::SEC_RED;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= in_vld;
    r1_r <= red; g1_r <= green; b1_r <= blue;
    mx1_r <= mx_nxt; mn1_r <= mn_nxt; sec1_r <= sec_nxt;
  end

  // stage 2: sum, spread, signed sector term
  logic [8:0] sum_nxt;
  logic [7:0] spr_nxt;
  logic signed [11:0] t_nxt;  // k*spread + diff, in -255..1275
  logic [8:0] sum2_r;
  logic [7:0] spr2_r;
  logic signed [11:0] t2_r;
  logic v2_r;

  always_comb begin
    sum_nxt = {1'b0, mx1_r} + {1'b0, mn1_r};
    spr_nxt = mx1_r - mn1_r;
    case (sec1_r)
      rgbhsl_pkg::SEC_BLUE:
        t_nxt = $signed({2'b00, spr_nxt, 2'b00}) + $signed({4'b0000, r1_r})
              - $signed({4'b0000, g1_r});
      rgbhsl_pkg::SEC_GREEN:
        t_nxt = $signed({3'b000, spr_nxt, 1'b0}) + $signed({4'b0000, b1_r})
              - $signed({4'b0000, r1_r});
      default:
        t_nxt = $signed({4'b0000, g1_r}) - $signed({4'b0000, b1_r});
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    sum2_r <= sum_nxt; spr2_r <= spr_nxt; t2_r <= t_nxt;
  end

  // stage 3: scale by 60/100, wrap, lightness
  logic signed [11:0] tw;
  logic [11:0] tu;
  logic [13:0] light_full;
  always_comb begin
    tw = (t2_r < 0) ? t2_r + $signed({4'b0000, spr2_r} * 12'd6) : t2_r;
    tu = tw;
    // lightness = floor(100*sum/510) = floor(10*sum/51)
    light_full = 14'(sum2_r) * 14'd10;
  end

  logic [16:0] hnum_r, snum_r;
  logic [8:0]  den_r, sden_r;
  logic [13:0] l10_r;
  logic        grey_r, v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    hnum_r <= 17'(tu) * 17'd60;
    snum_r <= 17'(spr2_r) * 17'd100;
    den_r  <= {1'b0, spr2_r};
    sden_r <= (sum2_r < 9'd255) ? sum2_r : 9'd510 - sum2_r;
    l10_r  <= light_full;
    grey_r <= (spr2_r == 8'd0);
  end

  // lightness: 10*sum/51 by reciprocal, 1285/65536 just under 1/51, then
  // one upward correction
  logic [27:0] lq_full;
  logic [6:0]  lq;
  logic [13:0] lrem;
  always_comb begin
    lq_full = 28'(l10_r) * 28'd1285;
    lq      = lq_full[22:16];
    lrem    = l10_r - 14'(lq) * 14'd51;
    if (lrem >= 14'd51) lq = lq + 7'd1;
  end

  assign out_vld = v3_r;
  always_comb begin
    out_data.hue_num = hnum_r;
    out_data.sat_num = snum_r;
    out_data.den     = den_r;
    out_data.sat_den = sden_r;
    out_data.light   = lq;
    out_data.grey    = grey_r;
  end

endmodule

// ----- hw/rtl/rgbhsl_div.sv -----
// Pipelined restoring divider pair: hue and saturation, one quotient bit per stage.
module rgbhsl_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  rgbhsl_pkg::front_t in_data,
  output logic               out_vld,
  output logic [rgbhsl_pkg::HueW-1:0] hue,
  output logic [rgbhsl_pkg::PctW-1:0] sat,
  output logic [rgbhsl_pkg::PctW-1:0] light
);
  localparam int unsigned N = rgbhsl_pkg::DivStgs;
  localparam int unsigned W = rgbhsl_pkg::NumW;

  logic [W-1:0] hq_r [N+1];   // shifts from dividend to quotient
  logic [9:0]   hr_r [N+1];   // partial remainder
  logic [W-1:0] sq_r [N+1];
  logic [9:0]   sr_r [N+1];
  logic [8:0]   hd_r [N+1];
  logic [8:0]   sd_r [N+1];
  logic [6:0]   l_r  [N+1];
  logic         g_r  [N+1];
  logic         v_r  [N+1];

  always_comb begin
    hq_r[0] = in_data.hue_num;
    sq_r[0] = in_data.sat_num;
    hr_r[0] = '0;
    sr_r[0] = '0;
    hd_r[0] = in_data.den;
    sd_r[0] = in_data.sat_den;
    l_r[0]  = in_data.light;
    g_r[0]  = in_data.grey;
    v_r[0]  = in_vld;
  end

  for (genvar i = 0; i < N; i++) begin : g_stg
    logic [9:0] htry, stry;
    logic       hge, sge;
    always_comb begin
      htry = {hr_r[i][8:0], hq_r[i][W-1]};
      stry = {sr_r[i][8:0], sq_r[i][W-1]};
      hge  = htry >= {1'b0, hd_r[i]};
      sge  = stry >= {1'b0, sd_r[i]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else        v_r[i+1] <= v_r[i];
      hr_r[i+1] <= hge ? htry - {1'b0, hd_r[i]} : htry;
      sr_r[i+1] <= sge ? stry - {1'b0, sd_r[i]} : stry;
      hq_r[i+1] <= {hq_r[i][W-2:0], hge};
      sq_r[i+1] <= {sq_r[i][W-2:0], sge};
      hd_r[i+1] <= hd_r[i];
      sd_r[i+1] <= sd_r[i];
      l_r[i+1]  <= l_r[i];
      g_r[i+1]  <= g_r[i];
    end
  end

  assign out_vld = v_r[N];
  assign hue     = g_r[N] ? '0 : hq_r[N][rgbhsl_pkg::HueW-1:0];
  assign sat     = g_r[N] ? '0 : sq_r[N][rgbhsl_pkg::PctW-1:0];
  assign light   = l_r[N];

endmodule

// ----- hw/rtl/rgb_to_hsl_converter.sv -----
// RGB to HSL converter.
// Input: drive in_red_in/in_green_in/in_blue_in with start high; a transfer
// happens at each edge where start is high and busy is low. busy is always
// low, so one pixel may be transferred every clock cycle.
// Output: out_strobe is high for one cycle with out_hue_deg (0..359 deg),
// out_saturation_pct and out_lightness_pct (0..100 %, truncated). The
// result transfers at the edge ending that cycle; the receiver cannot stall,
// and none is needed since nothing is ever held back.
// Pipeline: from the input transfer to the strobe cycle, three front-end
// stages (max/min, sum/spread, scaling), then seventeen divider stages, one
// quotient bit each, then the output register. Throughput is one pixel per
// cycle, set by the fully pipelined restoring dividers.
// Grey pixels give hue and saturation zero.
// Reset (rst_n low, synchronous) clears all valid bits; data in flight is
// dropped and no strobe appears until new pixels arrive.
`include "assert_macros.svh"
module rgb_to_hsl_converter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  output logic       out_strobe,
  output logic [8:0] out_hue_deg,
  output logic [6:0] out_saturation_pct,
  output logic [6:0] out_lightness_pct
);

  logic               f_vld, d_vld;
  rgbhsl_pkg::front_t f_data;
  logic [8:0]         d_hue;
  logic [6:0]         d_sat, d_light;

  assign busy = 1'b0;

  rgbhsl_front u_front (
    .clk, .rst_n, .in_vld(start & ~busy),
    .red(in_red_in), .green(in_green_in), .blue(in_blue_in),
    .out_vld(f_vld), .out_data(f_data)
  );

  rgbhsl_div u_div (
    .clk, .rst_n, .in_vld(f_vld), .in_data(f_data),
    .out_vld(d_vld), .hue(d_hue), .sat(d_sat), .light(d_light)
  );

  logic       strobe_r;
  logic [8:0] hue_r;
  logic [6:0] sat_r, light_r;
  always_ff @(posedge clk) begin
    if (!rst_n) strobe_r <= 1'b0;
    else        strobe_r <= d_vld;
    hue_r   <= d_hue;
    sat_r   <= d_sat;
    light_r <= d_light;
  end

  assign out_strobe         = strobe_r;
  assign out_hue_deg        = hue_r;
  assign out_saturation_pct = sat_r;
  assign out_lightness_pct  = light_r;

  `ASSERT_CLK(a_hue_range, clk, rst_n, out_strobe |-> out_hue_deg < 9'd360, "hue out of range")
  `ASSERT_CLK(a_sat_range, clk, rst_n, out_strobe |-> out_saturation_pct <= 7'd100, "sat out of range")
  `ASSERT_CLK(a_lat, clk, rst_n, d_vld |=> out_strobe, "strobe lost")
  `ASSERT_ALWAYS(a_rst, clk, !rst_n |=> !out_strobe, "strobe after reset")

endmodule
